>>> src/global_alignment_cost_traceback_assert.svh
// Assertion macros for the global alignment block.
// Each macro expects signals named clk and rst_n at the place of use.
`ifndef GLOBAL_ALIGNMENT_COST_TRACEBACK_ASSERT_SVH
`define GLOBAL_ALIGNMENT_COST_TRACEBACK_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define GACT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define GACT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gact_pkg.sv
`timescale 1ns / 1ps

package gact_pkg;

    localparam int COST_W       = 14;
    localparam int SUM_W        = COST_W + 1;
    localparam int GAP_W        = 8;
    localparam int LEN_W        = 6;
    localparam int IDX_W        = 6;
    localparam int PEN_W        = 8;
    localparam int PENALTY_BITS = 8;
    localparam int DEF_MAX_LEN  = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 32;
    localparam int OUT_PAD_W    = OUT_DATA_W - COST_W - 2 * IDX_W;

    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [PEN_W-1:0]  PEN_MASK = PEN_W'((64'd1 << PENALTY_BITS) - 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH_X = 2'd0,
        CFG_LENGTH_Y = 2'd1,
        CFG_GAP      = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIR_DIAG,
        DIR_UP,
        DIR_LEFT
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_TB_READ,
        ST_TB_STEP,
        ST_EMIT_COST,
        ST_EMIT_PAIR
    } state_t;

    typedef struct packed {
        dir_t              dir;
        logic [COST_W-1:0] cost;
    } cell_t;

    // Adds a cost and an 8-bit penalty, clamping at the largest cost.
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [GAP_W-1:0]  b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + SUM_W'(b);
        if (s > SUM_W'(COST_MAX))
        begin
            return COST_MAX;
        end
        return s[COST_W-1:0];
    endfunction

endpackage

>>> src/global_alignment_cost_traceback.sv
`timescale 1ns / 1ps
`include "global_alignment_cost_traceback_assert.svh"

// Minimum-cost global alignment of two sequences of length_x and length_y symbols
// (a length of zero acts as one, one above MAX_LEN acts as MAX_LEN). Each input item
// carries the mismatch penalty of the next cost cell in row-major order; a single
// shared cell unit computes one cell per item and stores its cost and choice in an
// internal memory of (MAX_LEN+1) squared entries. An item is taken only while idle,
// when the upper neighbor is read from the single read port of that memory; the cell
// is then computed and written. The item that completes the matrix starts a traceback
// of up to m + n - 1 steps for effective lengths m and n, each reading one cell via
// that read port, after which the block sends the total cost and then every matched
// pair in ascending order, one output item per cycle while the sink is ready; the last
// output item carries tlast. The memory needs no clearing after reset, and any write
// to a defined configuration register restarts the fill at the first cell.
module global_alignment_cost_traceback
    import gact_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] penalty
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [13:0] total_cost, [19:14] index_x,
                                                  // [25:20] index_y, [31:26] zero
    output logic                  m_axis_tuser,   // [0] pair_valid
    output logic                  m_axis_tlast
);

    localparam int DIM    = MAX_LEN + 1;
    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int SIDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    state_t state_reg;
    state_t state_next;

    logic [LEN_W-1:0] len_x_reg;
    logic [LEN_W-1:0] len_y_reg;
    logic [GAP_W-1:0] gap_reg;
    logic [POS_W-1:0] m_eff;
    logic [POS_W-1:0] n_eff;
    logic             cfg_hit;

    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] cnt_reg;
    logic [POS_W-1:0] pop_idx;
    logic [PEN_W-1:0] pen_reg;

    logic [COST_W-1:0] diag_reg;
    logic [COST_W-1:0] left_reg;
    logic [COST_W-1:0] top_edge_reg;
    logic [COST_W-1:0] edge_im1_reg;
    logic [COST_W-1:0] edge_i_reg;
    logic [COST_W-1:0] total_reg;

    logic [COST_W-1:0] up_val;
    logic [COST_W-1:0] diag_val;
    logic [COST_W-1:0] left_val;
    logic [COST_W-1:0] dsum;
    logic [COST_W-1:0] usum;
    logic [COST_W-1:0] lsum;
    logic [COST_W-1:0] best_cost;
    dir_t              best_dir;
    logic              first_row;
    logic              first_col;
    logic              last_cell;

    cell_t             mem [DEPTH];
    cell_t             rd_data_reg;
    cell_t             wr_cell;
    logic [POS_W-1:0]  rd_row;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    logic [POS_W-1:0] stack_x [MAX_LEN];
    logic [POS_W-1:0] stack_y [MAX_LEN];

    logic              out_valid_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic              out_pv_reg;
    logic [IDX_W-1:0]  out_x_reg;
    logic [IDX_W-1:0]  out_y_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              load_cost;
    logic              load_pair;
    logic              calc_en;
    logic              tb_done;

    // Effective lengths and configuration decode.
    always_comb
    begin
        if (len_x_reg == '0)
        begin
            m_eff = POS_W'(1);
        end
        else if (len_x_reg > LEN_W'(MAX_LEN))
        begin
            m_eff = POS_W'(MAX_LEN);
        end
        else
        begin
            m_eff = POS_W'(len_x_reg);
        end
        if (len_y_reg == '0)
        begin
            n_eff = POS_W'(1);
        end
        else if (len_y_reg > LEN_W'(MAX_LEN))
        begin
            n_eff = POS_W'(MAX_LEN);
        end
        else
        begin
            n_eff = POS_W'(len_y_reg);
        end
        cfg_hit = cfg_wr_en && (cfg_index == CFG_LENGTH_X || cfg_index == CFG_LENGTH_Y ||
                                cfg_index == CFG_GAP);
    end

    // Shared cell unit: neighbors come from the memory, the row and column edges,
    // or the previous cell of the same row.
    always_comb
    begin
        first_row = (row_reg == POS_W'(1));
        first_col = (col_reg == POS_W'(1));
        last_cell = (row_reg == m_eff) && (col_reg == n_eff);

        if (first_row)
        begin
            up_val = first_col ? COST_W'(gap_reg) : top_edge_reg;
        end
        else
        begin
            up_val = rd_data_reg.cost;
        end
        if (first_col)
        begin
            diag_val = first_row ? '0 : edge_im1_reg;
            left_val = first_row ? COST_W'(gap_reg) : edge_i_reg;
        end
        else
        begin
            diag_val = diag_reg;
            left_val = left_reg;
        end

        dsum = sat_add(diag_val, pen_reg);
        usum = sat_add(up_val, gap_reg);
        lsum = sat_add(left_val, gap_reg);

        best_cost = dsum;
        if (usum < best_cost)
        begin
            best_cost = usum;
        end
        if (lsum < best_cost)
        begin
            best_cost = lsum;
        end
        if (best_cost == dsum)
        begin
            best_dir = DIR_DIAG;
        end
        else if (best_cost == usum)
        begin
            best_dir = DIR_UP;
        end
        else
        begin
            best_dir = DIR_LEFT;
        end

        wr_cell.dir  = best_dir;
        wr_cell.cost = best_cost;
    end

    // Memory addressing: while idle the upper neighbor of the next cell is read.
    always_comb
    begin
        rd_row  = (state_reg == ST_IDLE) ? row_reg - POS_W'(1) : row_reg;
        rd_addr = ADDR_W'(rd_row) * ADDR_W'(DIM) + ADDR_W'(col_reg);
        wr_addr = ADDR_W'(row_reg) * ADDR_W'(DIM) + ADDR_W'(col_reg);
        pop_idx = cnt_reg - POS_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (calc_en)
        begin
            mem[wr_addr] <= wr_cell;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        load_cost     = 1'b0;
        load_pair     = 1'b0;
        calc_en       = 1'b0;
        tb_done       = 1'b0;
        out_free      = !out_valid_reg || m_axis_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                calc_en    = 1'b1;
                state_next = last_cell ? ST_TB_READ : ST_IDLE;
            end
            ST_TB_READ:
            begin
                if (row_reg == '0 || col_reg == '0)
                begin
                    tb_done    = 1'b1;
                    state_next = ST_EMIT_COST;
                end
                else
                begin
                    state_next = ST_TB_STEP;
                end
            end
            ST_TB_STEP:
            begin
                state_next = ST_TB_READ;
            end
            ST_EMIT_COST:
            begin
                if (out_free)
                begin
                    load_cost  = 1'b1;
                    state_next = (cnt_reg == '0) ? ST_IDLE : ST_EMIT_PAIR;
                end
            end
            ST_EMIT_PAIR:
            begin
                if (out_free)
                begin
                    load_pair  = 1'b1;
                    state_next = (cnt_reg == POS_W'(1)) ? ST_IDLE : ST_EMIT_PAIR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers and position control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_x_reg <= LEN_W'(1);
            len_y_reg <= LEN_W'(1);
            gap_reg   <= GAP_W'(1);
            row_reg   <= POS_W'(1);
            col_reg   <= POS_W'(1);
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_LENGTH_X: len_x_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_LENGTH_Y: len_y_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_GAP:      gap_reg   <= cfg_wdata[GAP_W-1:0];
                    default:      ;
                endcase
            end

            if (cfg_hit || tb_done)
            begin
                row_reg <= POS_W'(1);
                col_reg <= POS_W'(1);
            end
            else if (calc_en && !last_cell)
            begin
                if (col_reg < n_eff)
                begin
                    col_reg <= col_reg + POS_W'(1);
                end
                else
                begin
                    row_reg <= row_reg + POS_W'(1);
                    col_reg <= POS_W'(1);
                end
            end
            else if (state_reg == ST_TB_STEP)
            begin
                case (rd_data_reg.dir)
                    DIR_DIAG:
                    begin
                        row_reg <= row_reg - POS_W'(1);
                        col_reg <= col_reg - POS_W'(1);
                    end
                    DIR_UP:
                    begin
                        row_reg <= row_reg - POS_W'(1);
                    end
                    default:
                    begin
                        col_reg <= col_reg - POS_W'(1);
                    end
                endcase
            end

            if (calc_en && last_cell)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_TB_STEP && rd_data_reg.dir == DIR_DIAG &&
                     cnt_reg < POS_W'(MAX_LEN))
            begin
                cnt_reg <= cnt_reg + POS_W'(1);
            end
            else if (load_pair)
            begin
                cnt_reg <= pop_idx;
            end
        end
    end

    // Cell unit registers and the pair stack.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pen_reg <= s_axis_tdata & PEN_MASK;
        end
        if (calc_en)
        begin
            diag_reg <= up_val;
            left_reg <= best_cost;
            if (first_row)
            begin
                top_edge_reg <= usum;
            end
            if (first_col)
            begin
                edge_im1_reg <= left_val;
                edge_i_reg   <= lsum;
            end
            if (last_cell)
            begin
                total_reg <= best_cost;
            end
        end
        if (state_reg == ST_TB_STEP && rd_data_reg.dir == DIR_DIAG &&
            cnt_reg < POS_W'(MAX_LEN))
        begin
            stack_x[cnt_reg[SIDX_W-1:0]] <= row_reg;
            stack_y[cnt_reg[SIDX_W-1:0]] <= col_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_cost || load_pair)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cost)
        begin
            out_cost_reg <= total_reg;
            out_pv_reg   <= 1'b0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_last_reg <= (cnt_reg == '0);
        end
        else if (load_pair)
        begin
            out_cost_reg <= total_reg;
            out_pv_reg   <= 1'b1;
            out_x_reg    <= IDX_W'(stack_x[pop_idx[SIDX_W-1:0]]);
            out_y_reg    <= IDX_W'(stack_y[pop_idx[SIDX_W-1:0]]);
            out_last_reg <= (cnt_reg == POS_W'(1));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_y_reg, out_x_reg, out_cost_reg};
    assign m_axis_tuser  = out_pv_reg;
    assign m_axis_tlast  = out_last_reg;

    `GACT_ASSERT_ALWAYS(a_pos_in_range, state_reg != ST_IDLE || (row_reg != '0 && row_reg <= m_eff && col_reg != '0 && col_reg <= n_eff), "next cell position outside the matrix")
    `GACT_ASSERT_NEXT(a_accept_calc, s_axis_tvalid && s_axis_tready, state_reg == ST_CALC, "accepted item did not reach the cell unit")
    `GACT_ASSERT_ALWAYS(a_stack_bound, cnt_reg <= POS_W'(MAX_LEN), "pair stack count overflow")
    `GACT_ASSERT_ALWAYS(a_pair_index, !out_valid_reg || !out_pv_reg || (out_x_reg != '0 && out_y_reg != '0), "pair item with a zero index")

endmodule

>>> tb/tb_global_alignment_cost_traceback.sv
`timescale 1ns / 1ps

module tb_global_alignment_cost_traceback;
    import gact_pkg::*;

    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS    = 80;
    localparam int unsigned QUIET_FROM      = 60;

    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COST_W-1:0] total_cost;
        logic              pair_valid;
        logic [IDX_W-1:0]  index_x;
        logic [IDX_W-1:0]  index_y;
        logic              last;
    } align_result_t;

    class alignment_scoreboard;
        logic [LEN_W-1:0]  len_x_reg;
        logic [LEN_W-1:0]  len_y_reg;
        logic [GAP_W-1:0]  gap_reg;
        logic [COST_W-1:0] cost_mem [0:DEF_MAX_LEN][0:DEF_MAX_LEN];
        dir_t              dir_mem [0:DEF_MAX_LEN][0:DEF_MAX_LEN];
        int unsigned       row_next;
        int unsigned       col_next;
        align_result_t     expected_q[$];
        int unsigned       fail_count;

        function new();
            len_x_reg  = 1;
            len_y_reg  = 1;
            gap_reg    = 1;
            row_next   = 1;
            col_next   = 1;
            fail_count = 0;
        endfunction

        function int unsigned effective_length(logic [LEN_W-1:0] v);
            if (v == 0)
            begin
                return 1;
            end
            if (v > DEF_MAX_LEN)
            begin
                return DEF_MAX_LEN;
            end
            return v;
        endfunction

        function int unsigned clamp_cost(int unsigned s);
            return (s > COST_MAX) ? int'(COST_MAX) : s;
        endfunction

        function int unsigned cell_cost(int unsigned i, int unsigned j);
            if (i == 0)
            begin
                return clamp_cost(j * gap_reg);
            end
            if (j == 0)
            begin
                return clamp_cost(i * gap_reg);
            end
            return cost_mem[i][j];
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LENGTH_X: len_x_reg = value[LEN_W-1:0];
                CFG_LENGTH_Y: len_y_reg = value[LEN_W-1:0];
                CFG_GAP:      gap_reg   = value[GAP_W-1:0];
                default:      return;
            endcase
            row_next = 1;
            col_next = 1;
        endfunction

        function int unsigned pending_count();
            return expected_q.size();
        endfunction

        function void note_penalty(logic [PEN_W-1:0] pen_in);
            int unsigned   m;
            int unsigned   n;
            int unsigned   i;
            int unsigned   j;
            int unsigned   pen;
            int unsigned   diag_sum;
            int unsigned   up_sum;
            int unsigned   left_sum;
            int unsigned   best_sum;
            int unsigned   total;
            dir_t          pick;
            align_result_t res;
            align_result_t pairs[$];

            m   = effective_length(len_x_reg);
            n   = effective_length(len_y_reg);
            pen = pen_in & PEN_MASK;
            i   = row_next;
            j   = col_next;
            if (i < 1 || i > m || j < 1 || j > n)
            begin
                i = 1;
                j = 1;
            end

            diag_sum = clamp_cost(cell_cost(i - 1, j - 1) + pen);
            up_sum   = clamp_cost(cell_cost(i - 1, j) + gap_reg);
            left_sum = clamp_cost(cell_cost(i, j - 1) + gap_reg);
            best_sum = diag_sum;
            if (up_sum < best_sum)
            begin
                best_sum = up_sum;
            end
            if (left_sum < best_sum)
            begin
                best_sum = left_sum;
            end
            if (best_sum == diag_sum)
            begin
                pick = DIR_DIAG;
            end
            else if (best_sum == up_sum)
            begin
                pick = DIR_UP;
            end
            else
            begin
                pick = DIR_LEFT;
            end
            cost_mem[i][j] = best_sum[COST_W-1:0];
            dir_mem[i][j]  = pick;

            if (!(i == m && j == n))
            begin
                if (j < n)
                begin
                    col_next = j + 1;
                    row_next = i;
                end
                else
                begin
                    row_next = i + 1;
                    col_next = 1;
                end
                return;
            end

            total = cell_cost(m, n);
            while (i > 0 && j > 0)
            begin
                case (dir_mem[i][j])
                    DIR_DIAG:
                    begin
                        res.total_cost = total[COST_W-1:0];
                        res.pair_valid = 1'b1;
                        res.index_x    = i[IDX_W-1:0];
                        res.index_y    = j[IDX_W-1:0];
                        res.last       = 1'b0;
                        pairs.push_front(res);
                        i--;
                        j--;
                    end
                    DIR_UP:
                    begin
                        i--;
                    end
                    default:
                    begin
                        j--;
                    end
                endcase
            end

            res.total_cost = total[COST_W-1:0];
            res.pair_valid = 1'b0;
            res.index_x    = '0;
            res.index_y    = '0;
            res.last       = (pairs.size() == 0);
            expected_q.push_back(res);
            foreach (pairs[k])
            begin
                pairs[k].last = (k == pairs.size() - 1);
                expected_q.push_back(pairs[k]);
            end
            row_next = 1;
            col_next = 1;
        endfunction

        function void check_result(align_result_t got);
            align_result_t want;

            if (expected_q.size() == 0)
            begin
                $error("unexpected result: total_cost %0d pair_valid %0d index_x %0d index_y %0d",
                       got.total_cost, got.pair_valid, got.index_x, got.index_y);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.total_cost !== want.total_cost)
            begin
                $error("total_cost mismatch: expected %0d, actual %0d",
                       want.total_cost, got.total_cost);
                fail_count++;
            end
            if (got.pair_valid !== want.pair_valid)
            begin
                $error("pair_valid mismatch: expected %0d, actual %0d",
                       want.pair_valid, got.pair_valid);
                fail_count++;
            end
            if (got.index_x !== want.index_x)
            begin
                $error("index_x mismatch: expected %0d, actual %0d", want.index_x, got.index_x);
                fail_count++;
            end
            if (got.index_y !== want.index_y)
            begin
                $error("index_y mismatch: expected %0d, actual %0d", want.index_y, got.index_y);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
                fail_count++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    alignment_scoreboard sb;
    bit                  sender_gaps;
    bit                  quiet_tail;
    bit                  hold_off_req;

    global_alignment_cost_traceback dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        align_result_t got;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.total_cost = m_axis_tdata[COST_W-1:0];
            got.index_x    = m_axis_tdata[COST_W +: IDX_W];
            got.index_y    = m_axis_tdata[COST_W + IDX_W +: IDX_W];
            got.pair_valid = m_axis_tuser;
            got.last       = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // The long hold-off fills the block so that it has to stall its input.
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [PEN_W-1:0] pick_penalty(int unsigned gap_hint);
        int unsigned top;

        if ($urandom_range(0, 3) == 0)
        begin
            return PEN_W'($urandom_range(0, 255));
        end
        top = 2 * gap_hint + 1;
        if (top > 255)
        begin
            top = 255;
        end
        return PEN_W'($urandom_range(0, top));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_register(idx, value);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_penalty(input logic [PEN_W-1:0] pen);
        if (sender_gaps && !quiet_tail && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pen;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_penalty(pen);
    endtask

    task automatic send_cells(input int unsigned count, input int unsigned gap_hint);
        for (int unsigned k = 0; k < count; k++)
        begin
            send_penalty(pick_penalty(gap_hint));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_count() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned len_x;
        int unsigned len_y;
        int unsigned gap;
        int unsigned cells;

        sb            = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_LENGTH_X;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sender_gaps   = 1'b1;
        quiet_tail    = 1'b0;
        hold_off_req  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, one cell per run; a tie between diagonal and gap picks the diagonal.
        send_penalty(8'h00);
        send_penalty(8'hFF);
        send_penalty(8'h02);
        send_penalty(8'h55);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Zero lengths act as one.
        write_reg(CFG_LENGTH_X, 8'd0);
        write_reg(CFG_LENGTH_Y, 8'd0);
        write_reg(CFG_GAP, 8'hFF);
        send_penalty(8'hFF);
        send_penalty(8'h00);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        write_reg(CFG_LENGTH_X, 8'd2);
        write_reg(CFG_LENGTH_Y, 8'd3);
        write_reg(CFG_GAP, 8'd0);
        send_cells(6, 0);
        wait_drained();

        // A write in the middle of a fill restarts it; the unused index does not.
        write_reg(CFG_LENGTH_X, 8'd3);
        write_reg(CFG_LENGTH_Y, 8'd3);
        write_reg(CFG_GAP, 8'd2);
        send_cells(2, 2);
        wait_drained();
        write_reg(CFG_GAP, 8'd2);
        send_cells(4, 2);
        wait_drained();
        write_reg(CFG_UNUSED, 8'hFF);
        send_cells(5, 2);
        wait_drained();

        // Oversized lengths act as the largest size.
        write_reg(CFG_LENGTH_X, 8'd63);
        write_reg(CFG_LENGTH_Y, 8'd1);
        write_reg(CFG_GAP, 8'd255);
        send_cells(DEF_MAX_LEN, 255);
        wait_drained();

        write_reg(CFG_LENGTH_X, 8'd1);
        write_reg(CFG_LENGTH_Y, 8'd40);
        write_reg(CFG_GAP, 8'd7);
        send_cells(DEF_MAX_LEN, 7);
        wait_drained();

        write_reg(CFG_LENGTH_X, 8'd1);
        write_reg(CFG_LENGTH_Y, 8'd1);
        write_reg(CFG_GAP, 8'd3);
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        send_cells(12, 3);
        wait_drained();
        sender_gaps = 1'b1;

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= QUIET_FROM)
            begin
                quiet_tail = 1'b1;
            end
            len_x = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            len_y = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
            write_reg(CFG_LENGTH_X, CFG_DATA_W'(len_x));
            write_reg(CFG_LENGTH_Y, CFG_DATA_W'(len_y));
            write_reg(CFG_GAP, CFG_DATA_W'(gap));
            cells = sb.effective_length(LEN_W'(len_x)) * sb.effective_length(LEN_W'(len_y));
            if ($urandom_range(0, 7) == 0)
            begin
                cells = $urandom_range(1, cells);
            end
            send_cells(cells, gap);
            random_items += cells;
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending_count() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
